// ===== rtl/toy_spn_byte_cipher_top_assert.svh =====
// Assertion macros for the byte cipher top level.
`ifndef TOY_SPN_BYTE_CIPHER_TOP_ASSERT_SVH
`define TOY_SPN_BYTE_CIPHER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Antecedent in one cycle implies the consequent in the same cycle.
`define TSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsbc: same-cycle implication failed");
// Antecedent in one cycle implies the consequent in the next cycle.
`define TSBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsbc: next-cycle implication failed");
`else
`define TSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tsbc_pkg.sv =====
// Shared types, constants and table functions of the byte cipher.
package tsbc_pkg;

	// Number of cipher rounds; one pipeline stage per round.
	localparam int ROUNDS = 3;

	localparam int SBOX_W = 64;
	localparam int PERM_W = 24;
	localparam int KEYS_W = 32;
	localparam int CFG_W  = 64;
	localparam int IDX_W  = 3;

	localparam logic [SBOX_W-1:0] SBOX_RESET = 64'hFEDC_BA98_7654_3210;
	localparam logic [PERM_W-1:0] PERM_RESET = 24'hFA_C688;
	localparam logic [KEYS_W-1:0] KEYS_RESET = '0;

	localparam logic [3:0] NIBBLE = 4'hF;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_SBOX     = 3'd0,
		REG_INV_SBOX = 3'd1,
		REG_PERM     = 3'd2,
		REG_INV_PERM = 3'd3,
		REG_KEYS     = 3'd4
	} tsbc_reg_t;

	// Operation codes.
	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} tsbc_op_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [SBOX_W-1:0] sbox;
		logic [SBOX_W-1:0] inv_sbox;
		logic [PERM_W-1:0] perm;
		logic [PERM_W-1:0] inv_perm;
		logic [KEYS_W-1:0] keys;
	} tsbc_cfg_t;

	// One beat travelling down the pipeline.
	typedef struct packed {
		logic       valid;
		logic       op;
		logic [7:0] data;
	} tsbc_beat_t;

	// Substitute both nibbles through a 16-entry nibble table.
	function automatic logic [7:0] substitute(input logic [7:0] x,
		input logic [SBOX_W-1:0] tbl);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = tbl[4*(x[7:4] & NIBBLE) +: 4];
		lo = tbl[4*(x[3:0] & NIBBLE) +: 4];
		return {hi, lo};
	endfunction

	// Output bit b takes input bit tbl entry b.
	function automatic logic [7:0] permute(input logic [7:0] x,
		input logic [PERM_W-1:0] tbl);
		logic [7:0] y;
		y = '0;
		for (int b = 0; b < 8; b++) begin
			y[b] = x[tbl[3*b +: 3]];
		end
		return y;
	endfunction

	// Select round key j.
	function automatic logic [7:0] key_byte(input logic [KEYS_W-1:0] keys,
		input logic [1:0] j);
		return keys[8*j +: 8];
	endfunction

endpackage

// ===== rtl/tsbc_cfg.sv =====
// Configuration register file of the byte cipher.
module tsbc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tsbc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [tsbc_pkg::CFG_W-1:0]          cfg_wdata,
	output tsbc_pkg::tsbc_cfg_t                 cfg
);

	logic [tsbc_pkg::SBOX_W-1:0] sbox_q;
	logic [tsbc_pkg::SBOX_W-1:0] inv_sbox_q;
	logic [tsbc_pkg::PERM_W-1:0] perm_q;
	logic [tsbc_pkg::PERM_W-1:0] inv_perm_q;
	logic [tsbc_pkg::KEYS_W-1:0] keys_q;

	// Register writes; unknown indexes are ignored and upper bits dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox_q     <= tsbc_pkg::SBOX_RESET;
			inv_sbox_q <= tsbc_pkg::SBOX_RESET;
			perm_q     <= tsbc_pkg::PERM_RESET;
			inv_perm_q <= tsbc_pkg::PERM_RESET;
			keys_q     <= tsbc_pkg::KEYS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tsbc_pkg::REG_SBOX: begin
					sbox_q <= cfg_wdata[tsbc_pkg::SBOX_W-1:0];
				end
				tsbc_pkg::REG_INV_SBOX: begin
					inv_sbox_q <= cfg_wdata[tsbc_pkg::SBOX_W-1:0];
				end
				tsbc_pkg::REG_PERM: begin
					perm_q <= cfg_wdata[tsbc_pkg::PERM_W-1:0];
				end
				tsbc_pkg::REG_INV_PERM: begin
					inv_perm_q <= cfg_wdata[tsbc_pkg::PERM_W-1:0];
				end
				tsbc_pkg::REG_KEYS: begin
					keys_q <= cfg_wdata[tsbc_pkg::KEYS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.sbox     = sbox_q;
	assign cfg.inv_sbox = inv_sbox_q;
	assign cfg.perm     = perm_q;
	assign cfg.inv_perm = inv_perm_q;
	assign cfg.keys     = keys_q;

endmodule

// ===== rtl/tsbc_round.sv =====
// One registered round of the cipher, forward or inverse per beat.
module tsbc_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsbc_pkg::tsbc_cfg_t  cfg,
	input  logic [7:0]           key_enc,
	input  logic [7:0]           key_dec,
	input  tsbc_pkg::tsbc_beat_t beat_in,
	output tsbc_pkg::tsbc_beat_t beat_out
);

	logic [7:0] enc_x;
	logic [7:0] dec_x;
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] data_s1;

	// Forward round: key, S-box, permutation. Inverse round runs the reverse.
	always_comb begin
		enc_x = tsbc_pkg::permute(tsbc_pkg::substitute(beat_in.data ^ key_enc, cfg.sbox),
			cfg.perm);
		dec_x = tsbc_pkg::substitute(tsbc_pkg::permute(beat_in.data, cfg.inv_perm),
			cfg.inv_sbox) ^ key_dec;
	end

	// Valid bit is reset; payload is loaded only with a valid beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_in.valid) begin
			op_s1   <= beat_in.op;
			data_s1 <= (beat_in.op == tsbc_pkg::OP_DEC) ? dec_x : enc_x;
		end
	end

	assign beat_out.valid = valid_s1;
	assign beat_out.op    = op_s1;
	assign beat_out.data  = data_s1;

endmodule

// ===== rtl/toy_spn_byte_cipher_top.sv =====
// Byte cipher top level: an 8-bit substitution-permutation network, one byte per cycle.
//
// Usage: a byte is accepted at a rising edge where start is high and busy is
// low. op selects encryption (0) or decryption (1) of data_in. busy is always
// low, so a new byte can be accepted in every cycle.
// The result appears on data_out with done high for exactly one cycle, once the
// byte has passed one input register that applies the final key for decryption,
// one register stage per round, and an output register that applies the final
// key for encryption.
// Throughput is one byte per cycle; the depth is set by the round count.
// The receiver cannot hold results off, and the pipeline never stalls.
// Configuration registers (S-box, inverse S-box, permutation, inverse permutation,
// round keys) are written through cfg_we, cfg_index and cfg_wdata; the user must
// write them only while no byte is in flight, which the block does not enforce. Reset
// clears all in-flight beats and returns every table to identity and every key to zero.
`include "toy_spn_byte_cipher_top_assert.svh"

module toy_spn_byte_cipher_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [7:0]                    data_in,
	output logic                          done,
	output logic [7:0]                    data_out,
	input  logic                          cfg_we,
	input  logic [tsbc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tsbc_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int LAT = tsbc_pkg::ROUNDS + 2;
	localparam logic [1:0] KEY_FINAL = 2'(tsbc_pkg::ROUNDS);

	tsbc_pkg::tsbc_cfg_t  cfg;
	tsbc_pkg::tsbc_beat_t beat [0:tsbc_pkg::ROUNDS];
	logic [7:0]           key_final;
	logic                 valid_s1;
	logic                 op_s1;
	logic [7:0]           data_s1;
	logic                 done_q;
	logic [7:0]           data_out_q;

	// Configuration registers.
	tsbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign busy      = 1'b0;
	assign key_final = tsbc_pkg::key_byte(cfg.keys, KEY_FINAL);

	// Input stage; decryption starts by removing the final key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1   <= op;
			data_s1 <= (op == tsbc_pkg::OP_DEC) ? (data_in ^ key_final) : data_in;
		end
	end

	assign beat[0].valid = valid_s1;
	assign beat[0].op    = op_s1;
	assign beat[0].data  = data_s1;

	// One stage per round; decryption walks the keys in reverse order.
	for (genvar k = 0; k < tsbc_pkg::ROUNDS; k++) begin : g_round
		localparam logic [1:0] KEY_ENC = 2'(k);
		localparam logic [1:0] KEY_DEC = 2'(tsbc_pkg::ROUNDS - 1 - k);

		tsbc_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (cfg),
			.key_enc  (tsbc_pkg::key_byte(cfg.keys, KEY_ENC)),
			.key_dec  (tsbc_pkg::key_byte(cfg.keys, KEY_DEC)),
			.beat_in  (beat[k]),
			.beat_out (beat[k+1])
		);
	end

	// Output stage; encryption ends by adding the final key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= beat[tsbc_pkg::ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (beat[tsbc_pkg::ROUNDS].valid) begin
			data_out_q <= (beat[tsbc_pkg::ROUNDS].op == tsbc_pkg::OP_DEC)
				? beat[tsbc_pkg::ROUNDS].data
				: (beat[tsbc_pkg::ROUNDS].data ^ key_final);
		end
	end

	assign done     = done_q;
	assign data_out = data_out_q;

	// A result beat is always preceded by an accepted byte at the fixed latency.
	`TSBC_ASSERT_IMP(a_done_has_source, clk, arst_n, done, $past(start, LAT))
	// The last round stage always hands its beat to the output register.
	`TSBC_ASSERT_NXT(a_last_to_done, clk, arst_n, beat[tsbc_pkg::ROUNDS].valid, done)
	// Without an accepted byte the input stage stays empty.
	`TSBC_ASSERT_NXT(a_no_phantom_beat, clk, arst_n, !start, !beat[0].valid)

endmodule

// ===== test/tb_toy_spn_byte_cipher_top.sv =====
// Testbench of the byte cipher top level: directed and random bytes checked against a predictor.
`timescale 1ns / 100ps

module tb_toy_spn_byte_cipher_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = tsbc_pkg::ROUNDS + 6;
	localparam int MAX_GAP      = 13;
	localparam int PHASE_BYTES  = 235;

	localparam logic [7:0] EDGE_BYTES [8] = '{8'h00, 8'hFF, 8'h01, 8'h80,
		8'h0F, 8'hF0, 8'h55, 8'hAA};

	// Kinds of table and key settings used between phases.
	typedef enum {
		CFG_INVERTIBLE,
		CFG_ARBITRARY,
		CFG_ZEROS,
		CFG_ONES,
		CFG_IDENTITY_KEYED
	} cfg_mode_t;

	// One byte waiting to be sent, with its lead-in gap.
	typedef struct {
		tsbc_pkg::tsbc_op_t dir;
		logic [7:0]         data;
		int unsigned        gap;
		bit                 hold_for_drain;
	} byte_req_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	logic                           busy;
	logic                           op        = tsbc_pkg::OP_ENC;
	logic [7:0]                     data_in   = '0;
	logic                           done;
	logic [7:0]                     data_out;
	logic                           cfg_we    = 1'b0;
	logic [tsbc_pkg::IDX_W-1:0]     cfg_index = tsbc_pkg::REG_SBOX;
	logic [tsbc_pkg::CFG_W-1:0]     cfg_wdata = '0;

	tsbc_pkg::tsbc_cfg_t cipher_cfg = '{sbox: tsbc_pkg::SBOX_RESET,
		inv_sbox: tsbc_pkg::SBOX_RESET, perm: tsbc_pkg::PERM_RESET,
		inv_perm: tsbc_pkg::PERM_RESET, keys: tsbc_pkg::KEYS_RESET};
	byte_req_t   pending_bytes[$];
	logic [7:0]  expected_bytes[$];
	int unsigned issued_cnt = 0;
	int unsigned taken_cnt  = 0;
	int unsigned result_cnt = 0;
	int unsigned fault_cnt  = 0;
	int unsigned enc_cnt    = 0;
	int unsigned dec_cnt    = 0;
	int unsigned cfg_sets   = 0;

	// Driver state.
	bit          req_live  = 1'b0;
	bit          gap_armed = 1'b0;
	int unsigned gap_left  = 0;

	toy_spn_byte_cipher_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.data_in   (data_in),
		.done      (done),
		.data_out  (data_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Both nibbles go through the 16-entry table.
	function automatic logic [7:0] nibble_sub(input logic [7:0] x,
		input logic [tsbc_pkg::SBOX_W-1:0] tbl);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = 4'(tbl >> (x[7:4] * 4));
		lo = 4'(tbl >> (x[3:0] * 4));
		return {hi, lo};
	endfunction

	// Bit b of the output is bit tbl[b] of the input.
	function automatic logic [7:0] bit_shuffle(input logic [7:0] x,
		input logic [tsbc_pkg::PERM_W-1:0] tbl);
		logic [7:0] y;
		logic [2:0] src;
		y = '0;
		for (int b = 0; b < 8; b++) begin
			src = 3'(tbl >> (3 * b));
			y[b] = x[src];
		end
		return y;
	endfunction

	function automatic logic [7:0] round_key(input logic [tsbc_pkg::KEYS_W-1:0] keys,
		input int j);
		return 8'(keys >> (8 * (j % 4)));
	endfunction

	// Expected output byte for one accepted beat.
	function automatic logic [7:0] cipher_byte(input tsbc_pkg::tsbc_op_t dir,
		input logic [7:0] x_in, input tsbc_pkg::tsbc_cfg_t c);
		logic [7:0] x;
		x = x_in;
		if (dir == tsbc_pkg::OP_ENC) begin
			for (int r = 0; r < tsbc_pkg::ROUNDS; r++) begin
				x = bit_shuffle(nibble_sub(x ^ round_key(c.keys, r), c.sbox), c.perm);
			end
			x = x ^ round_key(c.keys, tsbc_pkg::ROUNDS);
		end else begin
			x = x ^ round_key(c.keys, tsbc_pkg::ROUNDS);
			for (int r = tsbc_pkg::ROUNDS - 1; r >= 0; r--) begin
				x = nibble_sub(bit_shuffle(x, c.inv_perm), c.inv_sbox) ^ round_key(c.keys, r);
			end
		end
		return x;
	endfunction

	// Driver: one beat per item, after its gap; a held item waits for all results first.
	always @(negedge clk) begin : byte_driver
		byte_req_t req;
		if (arst_n) begin
			if (req_live && taken_cnt == issued_cnt) begin
				req_live = 1'b0;
			end
			if (!req_live && pending_bytes.size() != 0) begin
				if (!gap_armed) begin
					gap_left  = pending_bytes[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left != 0) begin
					gap_left--;
				end else if (!pending_bytes[0].hold_for_drain || expected_bytes.size() == 0) begin
					req = pending_bytes.pop_front();
					op <= req.dir;
					data_in <= req.data;
					req_live = 1'b1;
					gap_armed = 1'b0;
					issued_cnt++;
				end
			end
			start <= req_live;
		end
	end

	// Monitor: check each result against the oldest expectation, then record new beats.
	always @(posedge clk) begin : result_monitor
		logic [7:0] want;
		if (arst_n) begin
			if (done) begin
				result_cnt++;
				if (expected_bytes.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= 10) begin
						$display("ERROR: result %02h arrived with no byte outstanding", data_out);
					end
				end else begin
					want = expected_bytes.pop_front();
					if (data_out !== want) begin
						fault_cnt++;
						if (fault_cnt <= 10) begin
							$display("ERROR: data_out expected %02h, got %02h (result %0d)",
								want, data_out, result_cnt);
						end
					end
				end
			end
			if (start && !busy) begin
				taken_cnt++;
				expected_bytes.push_back(cipher_byte(tsbc_pkg::tsbc_op_t'(op), data_in,
					cipher_cfg));
				if (op == tsbc_pkg::OP_DEC) begin
					dec_cnt++;
				end else begin
					enc_cnt++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("ERROR: no finish within %0d cycles", CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Write one register and mirror it into the predictor's copy.
	task automatic write_reg(input logic [tsbc_pkg::IDX_W-1:0] idx,
		input logic [tsbc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			tsbc_pkg::REG_SBOX: begin
				cipher_cfg.sbox = val;
			end
			tsbc_pkg::REG_INV_SBOX: begin
				cipher_cfg.inv_sbox = val;
			end
			tsbc_pkg::REG_PERM: begin
				cipher_cfg.perm = val[tsbc_pkg::PERM_W-1:0];
			end
			tsbc_pkg::REG_INV_PERM: begin
				cipher_cfg.inv_perm = val[tsbc_pkg::PERM_W-1:0];
			end
			tsbc_pkg::REG_KEYS: begin
				cipher_cfg.keys = val[tsbc_pkg::KEYS_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Build a full set of tables and keys and write them; unused indexes get noise.
	task automatic load_config(input cfg_mode_t mode);
		logic [tsbc_pkg::SBOX_W-1:0] sb;
		logic [tsbc_pkg::SBOX_W-1:0] isb;
		logic [tsbc_pkg::PERM_W-1:0] pm;
		logic [tsbc_pkg::PERM_W-1:0] ipm;
		logic [tsbc_pkg::KEYS_W-1:0] keys;
		int sh [16];
		int ph [8];
		int j;
		int t;
		sb   = {$urandom(), $urandom()};
		isb  = {$urandom(), $urandom()};
		pm   = 24'($urandom());
		ipm  = 24'($urandom());
		keys = $urandom();
		case (mode)
			CFG_INVERTIBLE: begin
				for (int i = 0; i < 16; i++) sh[i] = i;
				for (int i = 15; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = sh[i];
					sh[i] = sh[j];
					sh[j] = t;
				end
				for (int i = 0; i < 16; i++) begin
					sb[4*i +: 4] = 4'(sh[i]);
					isb[4*sh[i] +: 4] = 4'(i);
				end
				for (int i = 0; i < 8; i++) ph[i] = i;
				for (int i = 7; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = ph[i];
					ph[i] = ph[j];
					ph[j] = t;
				end
				for (int b = 0; b < 8; b++) begin
					pm[3*b +: 3] = 3'(ph[b]);
					ipm[3*ph[b] +: 3] = 3'(b);
				end
			end
			CFG_ZEROS: begin
				sb   = '0;
				isb  = '0;
				pm   = '0;
				ipm  = '0;
				keys = '0;
			end
			CFG_ONES: begin
				sb   = '1;
				isb  = '1;
				pm   = '1;
				ipm  = '1;
				keys = '1;
			end
			CFG_IDENTITY_KEYED: begin
				sb  = tsbc_pkg::SBOX_RESET;
				isb = tsbc_pkg::SBOX_RESET;
				pm  = tsbc_pkg::PERM_RESET;
				ipm = tsbc_pkg::PERM_RESET;
			end
			default: begin
			end
		endcase
		// Bits above the narrower registers carry noise that must be dropped.
		write_reg(tsbc_pkg::REG_SBOX, sb);
		write_reg(tsbc_pkg::REG_INV_SBOX, isb);
		write_reg(tsbc_pkg::REG_PERM, {$urandom(), 8'($urandom()), pm});
		write_reg(tsbc_pkg::REG_INV_PERM, {$urandom(), 8'($urandom()), ipm});
		write_reg(tsbc_pkg::REG_KEYS, {$urandom(), keys});
		for (int i = int'(tsbc_pkg::REG_KEYS) + 1; i < (1 << tsbc_pkg::IDX_W); i++) begin
			write_reg(tsbc_pkg::IDX_W'(i), {$urandom(), $urandom()});
		end
		cfg_sets++;
	endtask

	task automatic add_byte(input tsbc_pkg::tsbc_op_t dir, input logic [7:0] data,
		input int unsigned gap, input bit hold);
		byte_req_t req;
		req.dir = dir;
		req.data = data;
		req.gap = gap;
		req.hold_for_drain = hold;
		pending_bytes.push_back(req);
	endtask

	// Random bytes with random gaps and occasional back-to-back bursts.
	task automatic add_random_bytes(input int n, input bit force_hold);
		int burst_left;
		int unsigned gap;
		burst_left = 0;
		for (int k = 0; k < n; k++) begin
			if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(8, 30);
			end
			if (burst_left != 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = $urandom_range(0, MAX_GAP);
			end
			add_byte(tsbc_pkg::tsbc_op_t'($urandom_range(0, 1)), 8'($urandom()), gap,
				(force_hold && k == n / 2) || $urandom_range(0, 99) == 0);
		end
	endtask

	// Wait until every queued byte is taken and every result has come back.
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || taken_cnt != issued_cnt
			|| expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : main_sequence
		cfg_mode_t modes [8];
		modes = '{CFG_INVERTIBLE, CFG_ARBITRARY, CFG_ZEROS, CFG_ONES,
			CFG_INVERTIBLE, CFG_IDENTITY_KEYED, CFG_ARBITRARY, CFG_ARBITRARY};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Edge bytes in both directions with the tables as they come out of reset.
		foreach (EDGE_BYTES[i]) begin
			add_byte(tsbc_pkg::OP_ENC, EDGE_BYTES[i], $urandom_range(0, 2), 1'b0);
			add_byte(tsbc_pkg::OP_DEC, EDGE_BYTES[i], $urandom_range(0, 2), 1'b0);
		end
		wait_idle();

		// A few edge bytes under random arbitrary tables, whose permutation entries may repeat.
		load_config(CFG_ARBITRARY);
		for (int i = 0; i < 4; i++) begin
			add_byte(tsbc_pkg::OP_ENC, EDGE_BYTES[i], $urandom_range(0, 2), 1'b0);
			add_byte(tsbc_pkg::OP_DEC, EDGE_BYTES[i], $urandom_range(0, 2), 1'b0);
		end
		wait_idle();

		foreach (modes[p]) begin
			load_config(modes[p]);
			add_random_bytes(PHASE_BYTES, p == 0);
			wait_idle();
		end

		if (expected_bytes.size() != 0) begin
			fault_cnt++;
			$display("ERROR: %0d results never arrived", expected_bytes.size());
		end
		$display("Sent %0d encrypt and %0d decrypt beats, checked %0d results, %0d mismatches.",
			enc_cnt, dec_cnt, result_cnt, fault_cnt);
		$display("Covered %0d table and key sets: %s",
			cfg_sets + 1, "identity, invertible, arbitrary, all zeros, all ones.");
		if (fault_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
